/* rtl/scpa_pkg.sv */
// Shared types, constants and register codes for the size-class pool allocator.
// Used by every module of the allocator; depends on nothing.

package scpa_pkg;

   // Field widths fixed by the request and response formats.
   localparam int ADDR_W   = 16;
   localparam int SIZE_W   = 16;
   localparam int POOL_W   = 2;
   localparam int SLOT_W   = 3;
   localparam int NUM_POOLS = 4;
   localparam int MAX_SLOTS = 8;

   // Configuration port geometry.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_LO = 2;

   // Default slot counts per pool.
   localparam int DEF_SLOTS_A = 1;
   localparam int DEF_SLOTS_B = 1;
   localparam int DEF_SLOTS_C = 5;
   localparam int DEF_SLOTS_D = 5;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [POOL_W-1:0] pool_type;

   // Request kinds.
   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   // Register map, one word per register.
   typedef enum logic [2:0] {
      REG_CHUNK_SIZE_A = 3'd0,
      REG_CHUNK_SIZE_B = 3'd1,
      REG_CHUNK_SIZE_C = 3'd2,
      REG_CHUNK_SIZE_D = 3'd3,
      REG_BASE_ADDR_A  = 3'd4,
      REG_BASE_ADDR_B  = 3'd5,
      REG_BASE_ADDR_C  = 3'd6,
      REG_BASE_ADDR_D  = 3'd7
   } csr_reg_type;

   // Per-pool pool configuration as seen by the datapath.
   typedef struct packed {
      size_type chunk_size;
      addr_type base_addr;
   } pool_cfg_type;

   // Control from the top level to one pool for the beat being retired.
   typedef struct packed {
      logic         fire;
      req_kind_type kind;
      logic         grant;
      size_type     alloc_size;
      addr_type     free_address;
   } pool_req_type;

   // Status from one pool back to the top level.
   typedef struct packed {
      logic     avail;
      slot_type slot;
      addr_type addr;
      logic     hit;
   } pool_status_type;

endpackage

/* rtl/scpa_csr.sv */
// APB-style register file holding chunk sizes and base addresses of the four pools.
// Depends on scpa_pkg.

module scpa_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [scpa_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [scpa_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [scpa_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready,
   output scpa_pkg::pool_cfg_type [scpa_pkg::NUM_POOLS-1:0] pool_cfg
);

   scpa_pkg::size_type [scpa_pkg::NUM_POOLS-1:0] chunk_size_ff, chunk_size_in;
   scpa_pkg::addr_type [scpa_pkg::NUM_POOLS-1:0] base_addr_ff,  base_addr_in;
   scpa_pkg::csr_reg_type                        reg_sel;
   logic                                         wr_en;
   logic [scpa_pkg::SIZE_W-1:0]                  rd_word;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = scpa_pkg::csr_reg_type'(paddr[scpa_pkg::CSR_ADDR_W-1:scpa_pkg::CSR_IDX_LO]);

   // Write decode: one register per access beat.
   always_comb begin
      chunk_size_in = chunk_size_ff;
      base_addr_in  = base_addr_ff;
      if (wr_en) begin
         unique case (reg_sel)
            scpa_pkg::REG_CHUNK_SIZE_A: chunk_size_in[0] = pwdata[scpa_pkg::SIZE_W-1:0];
            scpa_pkg::REG_CHUNK_SIZE_B: chunk_size_in[1] = pwdata[scpa_pkg::SIZE_W-1:0];
            scpa_pkg::REG_CHUNK_SIZE_C: chunk_size_in[2] = pwdata[scpa_pkg::SIZE_W-1:0];
            scpa_pkg::REG_CHUNK_SIZE_D: chunk_size_in[3] = pwdata[scpa_pkg::SIZE_W-1:0];
            scpa_pkg::REG_BASE_ADDR_A:  base_addr_in[0]  = pwdata[scpa_pkg::ADDR_W-1:0];
            scpa_pkg::REG_BASE_ADDR_B:  base_addr_in[1]  = pwdata[scpa_pkg::ADDR_W-1:0];
            scpa_pkg::REG_BASE_ADDR_C:  base_addr_in[2]  = pwdata[scpa_pkg::ADDR_W-1:0];
            scpa_pkg::REG_BASE_ADDR_D:  base_addr_in[3]  = pwdata[scpa_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= '0;
         base_addr_ff  <= '0;
      end else begin
         chunk_size_ff <= chunk_size_in;
         base_addr_ff  <= base_addr_in;
      end
   end

   // Read decode.
   always_comb begin
      unique case (reg_sel)
         scpa_pkg::REG_CHUNK_SIZE_A: rd_word = chunk_size_ff[0];
         scpa_pkg::REG_CHUNK_SIZE_B: rd_word = chunk_size_ff[1];
         scpa_pkg::REG_CHUNK_SIZE_C: rd_word = chunk_size_ff[2];
         scpa_pkg::REG_CHUNK_SIZE_D: rd_word = chunk_size_ff[3];
         scpa_pkg::REG_BASE_ADDR_A:  rd_word = base_addr_ff[0];
         scpa_pkg::REG_BASE_ADDR_B:  rd_word = base_addr_ff[1];
         scpa_pkg::REG_BASE_ADDR_C:  rd_word = base_addr_ff[2];
         scpa_pkg::REG_BASE_ADDR_D:  rd_word = base_addr_ff[3];
         default:                    rd_word = '0;
      endcase
   end

   assign prdata = {{(scpa_pkg::CSR_DATA_W - scpa_pkg::SIZE_W){1'b0}}, rd_word};

   // Hand the configuration to the pools.
   always_comb begin
      for (int p = 0; p < scpa_pkg::NUM_POOLS; p++) begin
         pool_cfg[p].chunk_size = chunk_size_ff[p];
         pool_cfg[p].base_addr  = base_addr_ff[p];
      end
   end

endmodule

/* rtl/scpa_pool.sv */
// One pool: used flags, lowest-free search, slot addresses and free matching.
// Depends on scpa_pkg.

module scpa_pool #(
   parameter int SLOTS = scpa_pkg::DEF_SLOTS_A
) (
   input  logic                      clock,
   input  logic                      reset,
   input  scpa_pkg::pool_cfg_type    cfg,
   input  scpa_pkg::pool_req_type    req,
   output scpa_pkg::pool_status_type status
);

   logic [SLOTS-1:0]       used_ff, used_in;
   logic [SLOTS-1:0]       addr_hit;
   scpa_pkg::addr_type     slot_addr [SLOTS];
   logic                   any_free;
   scpa_pkg::slot_type     first_free;

   // Address of each slot, base plus slot times size, wrapping at 16 bits.
   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         slot_addr[s] = cfg.base_addr
                      + scpa_pkg::addr_type'(cfg.chunk_size * scpa_pkg::size_type'(s));
         addr_hit[s]  = (slot_addr[s] == req.free_address);
      end
   end

   // Lowest free slot; scanning down leaves the lowest one selected.
   always_comb begin
      any_free   = 1'b0;
      first_free = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (!used_ff[s]) begin
            any_free   = 1'b1;
            first_free = scpa_pkg::slot_type'(s);
         end
      end
   end

   // Status for the top level; the address is picked by comparing each slot number.
   always_comb begin
      status.avail = any_free && (cfg.chunk_size == req.alloc_size);
      status.slot  = first_free;
      status.addr  = slot_addr[0];
      for (int s = 0; s < SLOTS; s++) begin
         if (scpa_pkg::slot_type'(s) == first_free) begin
            status.addr = slot_addr[s];
         end
      end
      status.hit   = |addr_hit;
   end

   // Flag update when the beat retires.
   always_comb begin
      used_in = used_ff;
      if (req.fire) begin
         if (req.kind == scpa_pkg::REQ_FREE) begin
            used_in = used_ff & ~addr_hit;
         end else if (req.grant) begin
            for (int s = 0; s < SLOTS; s++) begin
               if (scpa_pkg::slot_type'(s) == first_free) begin
                  used_in[s] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

endmodule

/* rtl/size_class_pool_allocator.sv */
// Top level of the size-class pool allocator: request register, pool arbitration, response register.
// Depends on scpa_pkg, scpa_csr and scpa_pool.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_valid / req_ready     req_type, req_alloc_size, req_free_address
//   rsp_      out        rsp_valid / rsp_ready     rsp_success, rsp_chunk_address,
//                                                  rsp_pool_index, rsp_slot_index
//   csr       in/out     psel, penable, pready     paddr, pwdata, prdata, pwrite
//
// Each request is held in the request register and then retires into the response
// register, so one beat per cycle is sustained while rsp_ready stays high; the
// combinational path between them is the slot-address compare and the four-pool priority pick.
// Reset (synchronous) clears all used flags, the CSRs and the valid flags; no sweep is needed.
// A stalled response holds the request register; req_ready drops only while both are
// full and the response beat is held off.

module size_class_pool_allocator #(
   parameter int SLOTS_A = scpa_pkg::DEF_SLOTS_A,
   parameter int SLOTS_B = scpa_pkg::DEF_SLOTS_B,
   parameter int SLOTS_C = scpa_pkg::DEF_SLOTS_C,
   parameter int SLOTS_D = scpa_pkg::DEF_SLOTS_D
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [scpa_pkg::SIZE_W-1:0]         req_alloc_size,
   input  logic [scpa_pkg::ADDR_W-1:0]         req_free_address,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_success,
   output logic [scpa_pkg::ADDR_W-1:0]         rsp_chunk_address,
   output logic [scpa_pkg::POOL_W-1:0]         rsp_pool_index,
   output logic [scpa_pkg::SLOT_W-1:0]         rsp_slot_index,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [scpa_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [scpa_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [scpa_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int POOL_SLOTS [scpa_pkg::NUM_POOLS] = '{SLOTS_A, SLOTS_B, SLOTS_C, SLOTS_D};

   scpa_pkg::pool_cfg_type    [scpa_pkg::NUM_POOLS-1:0] pool_cfg;
   scpa_pkg::pool_req_type    [scpa_pkg::NUM_POOLS-1:0] pool_req;
   scpa_pkg::pool_status_type [scpa_pkg::NUM_POOLS-1:0] pool_status;

   logic                     req_valid_ff, req_valid_in;
   scpa_pkg::req_kind_type   req_kind_ff;
   scpa_pkg::size_type       alloc_size_ff;
   scpa_pkg::addr_type       free_address_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     success_ff, success_in;
   scpa_pkg::addr_type       chunk_address_ff, chunk_address_in;
   scpa_pkg::pool_type       pool_index_ff, pool_index_in;
   scpa_pkg::slot_type       slot_index_ff, slot_index_in;

   logic                                 advance;
   logic                                 load_req;
   logic [scpa_pkg::NUM_POOLS-1:0]       grant;
   logic                                 granted;
   logic                                 any_hit;
   scpa_pkg::pool_type                   grant_pool;

   // Configuration registers.
   scpa_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .pool_cfg (pool_cfg)
   );

   // Handshake: the held request retires into the response register when that register is empty or being read.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign load_req  = req_valid && req_ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (load_req) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) begin
         req_kind_ff     <= scpa_pkg::req_kind_type'(req_type);
         alloc_size_ff   <= req_alloc_size;
         free_address_ff <= req_free_address;
      end
   end

   // First pool in order A to D that matches the size and has a free slot wins.
   always_comb begin
      grant      = '0;
      granted    = 1'b0;
      grant_pool = '0;
      any_hit    = 1'b0;
      for (int p = 0; p < scpa_pkg::NUM_POOLS; p++) begin
         if (pool_status[p].avail && !granted) begin
            grant[p]   = 1'b1;
            granted    = 1'b1;
            grant_pool = scpa_pkg::pool_type'(p);
         end
         any_hit = any_hit | pool_status[p].hit;
      end
   end

   always_comb begin
      for (int p = 0; p < scpa_pkg::NUM_POOLS; p++) begin
         pool_req[p].fire         = advance;
         pool_req[p].kind         = req_kind_ff;
         pool_req[p].grant        = grant[p];
         pool_req[p].alloc_size   = alloc_size_ff;
         pool_req[p].free_address = free_address_ff;
      end
   end

   // The four pools.
   for (genvar g = 0; g < scpa_pkg::NUM_POOLS; g++) begin : g_pool
      scpa_pool #(
         .SLOTS (POOL_SLOTS[g])
      ) u_pool (
         .clock  (clock),
         .reset  (reset),
         .cfg    (pool_cfg[g]),
         .req    (pool_req[g]),
         .status (pool_status[g])
      );
   end

   // Response beat; failed allocations and frees carry zero address and indexes.
   always_comb begin
      success_in       = 1'b0;
      chunk_address_in = '0;
      pool_index_in    = '0;
      slot_index_in    = '0;
      if (req_kind_ff == scpa_pkg::REQ_FREE) begin
         success_in = any_hit;
      end else if (granted) begin
         success_in       = 1'b1;
         chunk_address_in = pool_status[grant_pool].addr;
         pool_index_in    = grant_pool;
         slot_index_in    = pool_status[grant_pool].slot;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         success_ff       <= success_in;
         chunk_address_ff <= chunk_address_in;
         pool_index_ff    <= pool_index_in;
         slot_index_ff    <= slot_index_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = success_ff;
   assign rsp_chunk_address = chunk_address_ff;
   assign rsp_pool_index    = pool_index_ff;
   assign rsp_slot_index    = slot_index_ff;

endmodule
